// File: sv/particle_pool_allocator_defines.svh
// Assertion macros used by the particle pool allocator back end.
`ifndef PARTICLE_POOL_ALLOCATOR_DEFINES_SVH
`define PARTICLE_POOL_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Check that prop holds at every rising clock edge outside reset.
`define PPA_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
// Check that cons holds in the cycle after ante.
`define PPA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PPA_ASSERT(name, clk, rst_n, prop, msg)
`define PPA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: sv/ppa_pkg.sv
// Types, codes and helpers shared by the particle pool allocator.
`default_nettype none

package ppa_pkg;

    localparam int POOL_SLOTS  = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_TICK = 2'd1,
        OP_DRAW = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        KIND_ASSIGNED = 2'd0,
        KIND_DRAWN    = 2'd1,
        KIND_EMPTY    = 2'd2
    } t_kind;

    localparam logic [CFG_IDX_W-1:0] CFG_DECAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS = 2'd1;

    localparam logic [15:0] DECAY_RESET = 16'd26;
    localparam logic [6:0]  SLOTS_RESET = 7'd64;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic [15:0]        start_life;
        logic [31:0]        tint;
        logic [14:0]        size;
        logic [15:0]        elapsed;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         kind;
        logic [5:0]         slot;
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [15:0] right;
        logic signed [15:0] bottom;
        logic [31:0]        shade;
        logic [6:0]         drawn_count;
        logic               last;
    } t_out_item;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        t_op                op;
        logic signed [15:0] corner_x;
        logic signed [15:0] corner_y;
        logic [15:0]        life;
        logic [31:0]        tint;
        logic [14:0]        size;
        logic [15:0]        elapsed;
    } t_cmd;

    // Per-slot attributes kept in the attribute memory.
    typedef struct packed {
        logic signed [15:0] corner_x;
        logic signed [15:0] corner_y;
        logic [31:0]        color;
        logic [14:0]        size;
    } t_attr;

    typedef struct packed {
        logic [15:0] decay_rate;
        logic [6:0]  slots_in_use;
    } t_cfg;

    localparam logic signed [17:0] SAT_HI = 18'sd32767;
    localparam logic signed [17:0] SAT_LO = -18'sd32768;

    // Clamp an 18-bit signed sum to the signed 16-bit range.
    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > SAT_HI) begin
            r = 16'sh7FFF;
        end else if (v < SAT_LO) begin
            r = 16'sh8000;
        end else begin
            r = 16'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/ppa_ifs.sv
// Handshake channel interfaces: input items, result items, configuration writes.
`default_nettype none

interface ppa_item_if;
    import ppa_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ppa_res_if;
    import ppa_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ppa_cfg_if;
    import ppa_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: sv/ppa_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module ppa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire                                    i_clk,
    input  wire                                    i_we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]                       i_wdata,
    input  wire                                    i_re,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

`default_nettype wire

// File: sv/ppa_front.sv
// Front end: accepts input items, drops unknown codes, works out the corner.
`default_nettype none

module ppa_front (
    input  wire            i_clk,
    input  wire            i_rst_n,
    ppa_item_if.sink       i_item,
    output logic           o_cmd_valid,
    output ppa_pkg::t_cmd  o_cmd,
    input  wire            i_cmd_ready
);
    import ppa_pkg::*;

    logic              r_valid;
    t_cmd              r_cmd;
    t_cmd              n_cmd;
    logic              known;
    logic              accept;
    logic [13:0]       half;
    logic signed [17:0] sum_x;
    logic signed [17:0] sum_y;

    assign i_item.ready = !r_valid || i_cmd_ready;
    assign accept       = i_item.valid && i_item.ready;

    always_comb begin
        unique case (i_item.data.operation)
            OP_ADD, OP_TICK, OP_DRAW: known = 1'b1;
            default:                  known = 1'b0;
        endcase
    end

    // Centre the square: corner is centre minus half the width, truncated.
    assign half  = i_item.data.size[14:1];
    assign sum_x = 18'(i_item.data.center_x) - $signed({4'b0000, half});
    assign sum_y = 18'(i_item.data.center_y) - $signed({4'b0000, half});

    always_comb begin
        n_cmd.op       = t_op'(i_item.data.operation);
        n_cmd.corner_x = sat16(sum_x);
        n_cmd.corner_y = sat16(sum_y);
        n_cmd.life     = i_item.data.start_life;
        n_cmd.tint     = i_item.data.tint;
        n_cmd.size     = i_item.data.size;
        n_cmd.elapsed  = i_item.data.elapsed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            // Load a known item, otherwise hold until the queue takes it.
            r_valid <= (accept && known) || (r_valid && !i_cmd_ready);
            if (accept && known) begin
                r_cmd <= n_cmd;
            end
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;
endmodule

`default_nettype wire

// File: sv/ppa_queue.sv
// Short command queue between the front end and the back end.
`default_nettype none

module ppa_queue (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push_valid,
    input  ppa_pkg::t_cmd  i_push,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output ppa_pkg::t_cmd  o_pop,
    input  wire            i_pop_ready
);
    import ppa_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_count;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_count != CW'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop        = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_mem[r_wp] <= i_push;
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end
endmodule

`default_nettype wire

// File: sv/ppa_back.sv
// Back end: slot search, life decay and draw walk over the particle pool.
`default_nettype none

`include "particle_pool_allocator_defines.svh"

module ppa_back #(
    parameter int SLOTS = ppa_pkg::POOL_SLOTS
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_cmd_valid,
    input  ppa_pkg::t_cmd  i_cmd,
    output logic           o_cmd_ready,
    input  ppa_pkg::t_cfg  i_cfg,
    ppa_res_if.source      o_res
);
    import ppa_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_SCAN,
        S_ADD_PUT,
        S_TICK_MUL,
        S_TICK_RUN,
        S_TICK_DRAIN,
        S_DRAW_COUNT,
        S_DRAW_SCAN,
        S_DRAW_PUT,
        S_DRAW_EMPTY
    } t_state;

    t_state        r_state;
    t_cmd          r_cmd;
    logic [6:0]    r_n;
    logic [IW-1:0] r_idx;
    logic [6:0]    r_cnt;
    logic [IW-1:0] r_ss;
    logic [IW-1:0] r_slot;
    logic [23:0]   r_dec;
    logic          r_wb_v;
    logic [IW-1:0] r_wb_idx;
    logic [6:0]    r_total;
    logic [6:0]    r_drawn;
    logic [SLOTS-1:0] r_live;
    logic          r_out_valid;
    t_out_item     r_out;

    logic [6:0]    n_lim;
    logic          n_out_valid;
    logic          idx_live;
    logic          at_end;
    logic [IW-1:0] idx_wrap;
    logic [IW-1:0] idx_inc;
    logic          out_free;
    logic [31:0]   prod;
    logic [23:0]   dec_calc;
    logic [15:0]   life_rdata;
    logic [15:0]   life_new;
    logic          life_we;
    logic [IW-1:0] life_waddr;
    logic [15:0]   life_wdata;
    logic          life_re;
    logic          attr_we;
    logic          attr_re;
    t_attr         attr_wdata;
    t_attr         attr_rdata;
    logic [6:0]    total_next;
    logic [6:0]    drawn_next;
    t_out_item     add_res;
    t_out_item     draw_res;
    t_out_item     empty_res;
    logic signed [17:0] add_r;
    logic signed [17:0] add_b;
    logic signed [17:0] draw_r;
    logic signed [17:0] draw_b;

    assign n_lim = (i_cfg.slots_in_use > 7'(SLOTS)) ? 7'(SLOTS) : i_cfg.slots_in_use;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign idx_live    = r_live[r_idx];
    assign at_end      = (r_cnt == r_n - 7'd1);
    assign idx_inc     = r_idx + IW'(1);
    assign idx_wrap    = (7'(r_idx) == r_n - 7'd1) ? '0 : idx_inc;
    assign out_free    = !r_out_valid || o_res.ready;
    assign total_next  = r_total + 7'(idx_live);
    assign drawn_next  = r_drawn + 7'd1;

    // Load a result in the emitting states, otherwise hold it until taken.
    assign n_out_valid = (((r_state == S_ADD_PUT) || (r_state == S_DRAW_PUT) ||
                           (r_state == S_DRAW_EMPTY)) && out_free) ||
                         (r_out_valid && !o_res.ready);

    // Decrement per tick, rounded half up in 8.8.
    assign prod     = 32'(i_cfg.decay_rate) * 32'(r_cmd.elapsed);
    assign dec_calc = 24'((prod + 32'd128) >> 8);

    assign life_new = ({8'd0, life_rdata} > r_dec) ? life_rdata - r_dec[15:0] : 16'd0;

    // Life store: add writes the new life, tick writes back one slot behind the read.
    always_comb begin
        if (r_state == S_ADD_PUT) begin
            life_we    = out_free;
            life_waddr = r_slot;
            life_wdata = r_cmd.life;
        end else begin
            life_we    = r_wb_v && ((r_state == S_TICK_RUN) || (r_state == S_TICK_DRAIN));
            life_waddr = r_wb_idx;
            life_wdata = life_new;
        end
    end
    assign life_re = (r_state == S_TICK_RUN) && idx_live;

    assign attr_we             = (r_state == S_ADD_PUT) && out_free;
    assign attr_re             = (r_state == S_DRAW_SCAN) && idx_live;
    assign attr_wdata.corner_x = r_cmd.corner_x;
    assign attr_wdata.corner_y = r_cmd.corner_y;
    assign attr_wdata.color    = r_cmd.tint;
    assign attr_wdata.size     = r_cmd.size;

    ppa_ram #(
        .WIDTH (16),
        .DEPTH (SLOTS)
    ) u_life_ram (
        .i_clk   (i_clk),
        .i_we    (life_we),
        .i_waddr (life_waddr),
        .i_wdata (life_wdata),
        .i_re    (life_re),
        .i_raddr (r_idx),
        .o_rdata (life_rdata)
    );

    ppa_ram #(
        .WIDTH ($bits(t_attr)),
        .DEPTH (SLOTS)
    ) u_attr_ram (
        .i_clk   (i_clk),
        .i_we    (attr_we),
        .i_waddr (r_slot),
        .i_wdata (attr_wdata),
        .i_re    (attr_re),
        .i_raddr (r_idx),
        .o_rdata (attr_rdata)
    );

    assign add_r  = 18'(r_cmd.corner_x) + $signed({3'b000, r_cmd.size});
    assign add_b  = 18'(r_cmd.corner_y) + $signed({3'b000, r_cmd.size});
    assign draw_r = 18'(attr_rdata.corner_x) + $signed({3'b000, attr_rdata.size});
    assign draw_b = 18'(attr_rdata.corner_y) + $signed({3'b000, attr_rdata.size});

    always_comb begin
        add_res.kind        = KIND_ASSIGNED;
        add_res.slot        = 6'(r_slot);
        add_res.left        = r_cmd.corner_x;
        add_res.top         = r_cmd.corner_y;
        add_res.right       = sat16(add_r);
        add_res.bottom      = sat16(add_b);
        add_res.shade       = r_cmd.tint;
        add_res.drawn_count = 7'd0;
        add_res.last        = 1'b1;

        draw_res.kind        = KIND_DRAWN;
        draw_res.slot        = 6'(r_idx);
        draw_res.left        = attr_rdata.corner_x;
        draw_res.top         = attr_rdata.corner_y;
        draw_res.right       = sat16(draw_r);
        draw_res.bottom      = sat16(draw_b);
        draw_res.shade       = attr_rdata.color;
        draw_res.drawn_count = drawn_next;
        draw_res.last        = (drawn_next == r_total);

        empty_res      = '0;
        empty_res.kind = KIND_EMPTY;
        empty_res.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_live      <= '0;
            r_ss        <= '0;
            r_wb_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        r_n   <= n_lim;
                        r_cnt <= 7'd0;
                        unique case (i_cmd.op)
                            OP_ADD: begin
                                if (n_lim == 7'd0) begin
                                    r_slot  <= '0;
                                    r_state <= S_ADD_PUT;
                                end else begin
                                    r_idx   <= (7'(r_ss) < n_lim) ? r_ss : '0;
                                    r_state <= S_ADD_SCAN;
                                end
                            end
                            OP_TICK: begin
                                r_state <= S_TICK_MUL;
                            end
                            OP_DRAW: begin
                                r_idx   <= '0;
                                r_total <= 7'd0;
                                r_state <= (n_lim == 7'd0) ? S_DRAW_EMPTY : S_DRAW_COUNT;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_ADD_SCAN: begin
                    if (!idx_live) begin
                        r_slot  <= r_idx;
                        r_ss    <= r_idx;
                        r_state <= S_ADD_PUT;
                    end else if (at_end) begin
                        r_slot  <= '0;
                        r_state <= S_ADD_PUT;
                    end else begin
                        r_idx <= idx_wrap;
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_ADD_PUT: begin
                    if (out_free) begin
                        r_live[r_slot] <= (r_cmd.life != 16'd0);
                        r_out          <= add_res;
                        r_state        <= S_IDLE;
                    end
                end
                S_TICK_MUL: begin
                    r_dec   <= dec_calc;
                    r_idx   <= '0;
                    r_wb_v  <= 1'b0;
                    r_state <= (r_n == 7'd0) ? S_IDLE : S_TICK_RUN;
                end
                S_TICK_RUN: begin
                    if (r_wb_v) begin
                        r_live[r_wb_idx] <= (life_new != 16'd0);
                    end
                    r_wb_v   <= idx_live;
                    r_wb_idx <= r_idx;
                    if (at_end) begin
                        r_state <= S_TICK_DRAIN;
                    end else begin
                        r_idx <= idx_inc;
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_TICK_DRAIN: begin
                    if (r_wb_v) begin
                        r_live[r_wb_idx] <= (life_new != 16'd0);
                    end
                    r_wb_v  <= 1'b0;
                    r_state <= S_IDLE;
                end
                S_DRAW_COUNT: begin
                    r_total <= total_next;
                    if (at_end) begin
                        r_idx   <= '0;
                        r_cnt   <= 7'd0;
                        r_drawn <= 7'd0;
                        r_state <= (total_next == 7'd0) ? S_DRAW_EMPTY : S_DRAW_SCAN;
                    end else begin
                        r_idx <= idx_inc;
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_DRAW_SCAN: begin
                    if (idx_live) begin
                        r_state <= S_DRAW_PUT;
                    end else if (at_end) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= idx_inc;
                        r_cnt <= r_cnt + 7'd1;
                    end
                end
                S_DRAW_PUT: begin
                    if (out_free) begin
                        r_out       <= draw_res;
                        r_drawn     <= drawn_next;
                        if ((drawn_next == r_total) || at_end) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= idx_inc;
                            r_cnt   <= r_cnt + 7'd1;
                            r_state <= S_DRAW_SCAN;
                        end
                    end
                end
                S_DRAW_EMPTY: begin
                    if (out_free) begin
                        r_out       <= empty_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    `PPA_ASSERT(a_tick_no_result, i_clk, i_rst_n, !((r_state == S_TICK_RUN) && $rose(r_out_valid)), "tick produced a result")
    `PPA_ASSERT(a_draw_bound, i_clk, i_rst_n, (r_state != S_DRAW_PUT) || (r_drawn < r_total), "draw walk past live total")
    `PPA_ASSERT(a_wb_clash, i_clk, i_rst_n, !((r_state == S_TICK_RUN) && r_wb_v && (r_wb_idx == r_idx)), "tick write-back clashes with read")
    `PPA_ASSERT_NEXT(a_add_live, i_clk, i_rst_n, (r_state == S_ADD_PUT) && out_free, r_live[$past(r_slot)] == ($past(r_cmd.life) != 16'd0), "add left wrong live flag")
endmodule

`default_nettype wire

// File: sv/particle_pool_allocator.sv
// Top level of the particle pool allocator: configuration, front end, queue, back end.
//
//   channel   modport  direction  moves
//   i_item    sink     in         add, tick or draw request item
//   o_res     source   out        slot assigned, particle drawn or empty-draw item
//   i_cfg     sink     in         register write (0 decay rate, 1 slots in use)
//
// An item passes through the front register, then the queue, to the back end.
// The back end scans the pool one slot a cycle, n = min(slots_in_use, SLOTS), and
// waits while a result stalls: add seeks a dead slot and writes it; tick decays
// each live slot; draw counts live slots, then emits each one or an empty item.
// Life is cleared at reset through per-slot live flags, so no clearing pass runs.
// A stalled result holds in the output register; the queue takes items till full.
`default_nettype none

module particle_pool_allocator #(
    parameter int SLOTS = ppa_pkg::POOL_SLOTS
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    ppa_item_if.sink   i_item,
    ppa_res_if.source  o_res,
    ppa_cfg_if.sink    i_cfg
);
    import ppa_pkg::*;

    logic [15:0] r_decay;
    logic [6:0]  r_slots;
    t_cfg        cfg;

    logic front_valid;
    t_cmd front_cmd;
    logic front_ready;
    logic back_valid;
    t_cmd back_cmd;
    logic back_ready;

    // Register writes are always taken; unknown indexes are dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay <= DECAY_RESET;
            r_slots <= SLOTS_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_DECAY: r_decay <= i_cfg.data;
                CFG_SLOTS: r_slots <= i_cfg.data[6:0];
                default:   r_decay <= r_decay;
            endcase
        end
    end

    assign cfg.decay_rate   = r_decay;
    assign cfg.slots_in_use = r_slots;

    // Classify and pre-compute the corner of each accepted item.
    ppa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .o_cmd_valid (front_valid),
        .o_cmd       (front_cmd),
        .i_cmd_ready (front_ready)
    );

    // Hold commands while the back end is busy walking the pool.
    ppa_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push       (front_cmd),
        .o_push_ready (front_ready),
        .o_pop_valid  (back_valid),
        .o_pop        (back_cmd),
        .i_pop_ready  (back_ready)
    );

    // Carry out search, decay and draw over the slot stores.
    ppa_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (back_valid),
        .i_cmd       (back_cmd),
        .o_cmd_ready (back_ready),
        .i_cfg       (cfg),
        .o_res       (o_res)
    );
endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for the particle pool allocator: directed and random requests against a pool mirror.
module testbench;
    import ppa_pkg::*;

    // Operation code with no meaning to the block; such an item must vanish without trace.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Give up after this many cycles.
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    // Quiet time after the last result: covers ticks over a full pool waiting in the front
    // register, the queue and the back end, several times over.
    localparam int unsigned DRAIN_CYCLES = 1000;
    // Length of the receiver hold-off in the back-pressure phase.
    localparam int unsigned HOLD_OFF_CYCLES = 400;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ppa_item_if item_ch ();
    ppa_res_if  res_ch ();
    ppa_cfg_if  cfg_ch ();

    particle_pool_allocator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Pool mirror: our own copy of every slot, the next-fit pointer and
    // both registers, advanced once per accepted item.
    // ------------------------------------------------------------------
    logic [15:0]        life_m   [POOL_SLOTS];
    logic signed [15:0] left_m   [POOL_SLOTS];
    logic signed [15:0] top_m    [POOL_SLOTS];
    logic [31:0]        colour_m [POOL_SLOTS];
    logic [14:0]        width_m  [POOL_SLOTS];
    int unsigned        rover;
    logic [15:0]        decay_m;
    logic [6:0]         span_m;

    t_in_item    requests_to_send [$];
    t_out_item   reports_due [$];
    int unsigned faults = 0;
    int unsigned cycles = 0;
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_left = 0;
    bit          item_taken = 1'b0;

    // Register values above the pool size behave as the full pool.
    function automatic int unsigned live_span();
        return (span_m > POOL_SLOTS) ? POOL_SLOTS : int'(span_m);
    endfunction

    function automatic logic signed [15:0] clip16(input int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return 16'(v);
    endfunction

    // Search from the remembered slot to the end of the span, then wrap to the start.
    // With no dead slot, fall back to slot 0 and leave the pointer alone.
    function automatic int unsigned next_fit_slot();
        int unsigned n;
        n = live_span();
        for (int unsigned i = rover; i < n; i++) begin
            if (life_m[i] == 16'd0) begin
                rover = i;
                return i;
            end
        end
        for (int unsigned i = 0; i < rover && i < n; i++) begin
            if (life_m[i] == 16'd0) begin
                rover = i;
                return i;
            end
        end
        return 0;
    endfunction

    function automatic t_out_item slot_report(input t_kind k, input int unsigned s,
                                              input int unsigned cnt, input logic fin);
        t_out_item r;
        r.kind        = k;
        r.slot        = 6'(s);
        r.left        = left_m[s];
        r.top         = top_m[s];
        r.right       = clip16(int'(left_m[s]) + int'(width_m[s]));
        r.bottom      = clip16(int'(top_m[s]) + int'(width_m[s]));
        r.shade       = colour_m[s];
        r.drawn_count = 7'(cnt);
        r.last        = fin;
        return r;
    endfunction

    // Apply one accepted item to the mirror and queue the results it must produce.
    task automatic mirror_request(input t_in_item it);
        int unsigned n;
        int unsigned s;
        int unsigned total;
        int unsigned cnt;
        logic [31:0] cut;
        t_out_item   nothing_live;
        n = live_span();
        case (it.operation)
            OP_ADD: begin
                s = next_fit_slot();
                life_m[s]   = it.start_life;
                left_m[s]   = clip16(int'(it.center_x) - int'(it.size >> 1));
                top_m[s]    = clip16(int'(it.center_y) - int'(it.size >> 1));
                colour_m[s] = it.tint;
                width_m[s]  = it.size;
                reports_due.push_back(slot_report(KIND_ASSIGNED, s, 0, 1'b1));
            end
            OP_TICK: begin
                // Round the 8.8 product half up, then saturate each life at zero.
                cut = (32'(decay_m) * 32'(it.elapsed) + 32'd128) >> 8;
                for (int unsigned i = 0; i < n; i++) begin
                    if (life_m[i] != 16'd0) begin
                        life_m[i] = (life_m[i] > cut) ? life_m[i] - 16'(cut) : 16'd0;
                    end
                end
            end
            OP_DRAW: begin
                total = 0;
                for (int unsigned i = 0; i < n; i++) begin
                    if (life_m[i] != 16'd0) total++;
                end
                if (total == 0) begin
                    nothing_live      = '0;
                    nothing_live.kind = KIND_EMPTY;
                    nothing_live.last = 1'b1;
                    reports_due.push_back(nothing_live);
                end else begin
                    cnt = 0;
                    for (int unsigned i = 0; i < n; i++) begin
                        if (life_m[i] != 16'd0) begin
                            cnt++;
                            reports_due.push_back(slot_report(KIND_DRAWN, i, cnt,
                                                              cnt == total));
                        end
                    end
                end
            end
            default: begin
                // unused code: no result, no state change
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------
    // Fill every field with noise, then set the operation.
    function automatic t_in_item blank_req(input logic [1:0] op);
        t_in_item r;
        r.operation  = op;
        r.center_x   = 16'($urandom);
        r.center_y   = 16'($urandom);
        r.start_life = 16'($urandom);
        r.tint       = $urandom;
        r.size       = 15'($urandom);
        r.elapsed    = 16'($urandom);
        return r;
    endfunction

    function automatic t_in_item add_req(input logic [15:0] cx, input logic [15:0] cy,
                                         input logic [15:0] life, input logic [31:0] tint,
                                         input logic [14:0] size);
        t_in_item r;
        r            = blank_req(OP_ADD);
        r.center_x   = cx;
        r.center_y   = cy;
        r.start_life = life;
        r.tint       = tint;
        r.size       = size;
        return r;
    endfunction

    function automatic t_in_item tick_req(input logic [15:0] el);
        t_in_item r;
        r         = blank_req(OP_TICK);
        r.elapsed = el;
        return r;
    endfunction

    // Mostly adds and draws; lives and time steps lean small so that ticks really kill
    // particles, with full-range values mixed in to reach the saturation corners.
    function automatic t_in_item random_request();
        t_in_item    r;
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 45) begin
            r = blank_req(OP_ADD);
            case ($urandom_range(9))
                0:       r.start_life = 16'd0;
                1, 2, 3: r.start_life = 16'($urandom);
                default: r.start_life = 16'($urandom_range(1, 2047));
            endcase
            if ($urandom_range(9) < 7) r.size = 15'($urandom_range(0, 511));
        end else if (roll < 65) begin
            r = blank_req(OP_TICK);
            if ($urandom_range(9) < 7) r.elapsed = 16'($urandom_range(0, 1023));
        end else if (roll < 95) begin
            r = blank_req(OP_DRAW);
        end else begin
            r = blank_req(OP_UNUSED);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers: change inputs on the falling edge only.
    // ------------------------------------------------------------------
    // Hold an offered item until taken, then offer the next one or idle.
    always @(negedge i_clk) begin
        if (!item_ch.valid || item_taken) begin
            item_taken = 1'b0;
            if (requests_to_send.size() != 0 && $urandom_range(99) >= gap_pct) begin
                item_ch.valid <= 1'b1;
                item_ch.data  <= requests_to_send.pop_front();
            end else begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    // Stall results at random, and all the time while a hold-off is running.
    always @(negedge i_clk) begin
        res_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end

    // Count the hold-off down in its own process.
    always @(posedge i_clk) begin
        if (hold_left != 0) hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------
    // Monitor: sample both channels on the rising edge.
    // ------------------------------------------------------------------
    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: result %s mismatch, expected %0h, got %0h", $time, what, want, got);
            faults++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (item_ch.valid && item_ch.ready) begin
                mirror_request(item_ch.data);
                item_taken = 1'b1;
            end
            if (res_ch.valid && res_ch.ready) begin
                if (reports_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got kind %0d slot %0d",
                             $time, res_ch.data.kind, res_ch.data.slot);
                    faults++;
                end else begin
                    want = reports_due.pop_front();
                    check_field("kind", 32'(want.kind), 32'(res_ch.data.kind));
                    check_field("slot", 32'(want.slot), 32'(res_ch.data.slot));
                    check_field("left", 32'(want.left), 32'(res_ch.data.left));
                    check_field("top", 32'(want.top), 32'(res_ch.data.top));
                    check_field("right", 32'(want.right), 32'(res_ch.data.right));
                    check_field("bottom", 32'(want.bottom), 32'(res_ch.data.bottom));
                    check_field("shade", want.shade, res_ch.data.shade);
                    check_field("drawn_count", 32'(want.drawn_count),
                                32'(res_ch.data.drawn_count));
                    check_field("last", 32'(want.last), 32'(res_ch.data.last));
                end
            end
        end
    end

    // Watchdog: stop a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, reports_due.size());
            $display("FAIL particle_pool_allocator");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------
    // Write one register and mirror it on the accepting edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        if (idx == CFG_DECAY) decay_m = val;
        else if (idx == CFG_SLOTS) span_m = val[6:0];
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Wait for every item to be taken and every result to arrive, then let a tick
    // still walking the pool finish before anything else happens.
    task automatic settle();
        while (requests_to_send.size() != 0 || item_ch.valid || reports_due.size() != 0 ||
               hold_left != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input int unsigned gap, input int unsigned stall,
                             input logic [15:0] decay, input logic [15:0] span,
                             input int unsigned count, input bit squeeze);
        gap_pct   = gap;
        stall_pct = stall;
        write_reg(CFG_DECAY, decay);
        write_reg(CFG_SLOTS, span);
        @(posedge i_clk);
        // Hold results back while the sender keeps pushing, so the queue fills.
        if (squeeze) hold_left <= HOLD_OFF_CYCLES;
        repeat (count) requests_to_send.push_back(random_request());
        settle();
    endtask

    initial begin
        item_ch.valid = 1'b0;
        item_ch.data  = '0;
        res_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.data   = '0;
        i_rst_n       = 1'b0;
        for (int i = 0; i < POOL_SLOTS; i++) begin
            life_m[i]   = '0;
            left_m[i]   = '0;
            top_m[i]    = '0;
            colour_m[i] = '0;
            width_m[i]  = '0;
        end
        rover   = 0;
        decay_m = DECAY_RESET;
        span_m  = SLOTS_RESET;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty pool, ignored code, tick on nothing, then adds at the field extremes:
        // a dead add, corners saturating both ways, a zero and a unit width.
        requests_to_send.push_back(blank_req(OP_DRAW));
        requests_to_send.push_back(blank_req(OP_UNUSED));
        requests_to_send.push_back(tick_req(16'h0100));
        requests_to_send.push_back(add_req(16'h0000, 16'h0000, 16'h0000, $urandom, 15'h0010));
        requests_to_send.push_back(add_req(16'h7FFF, 16'h8000, 16'hFFFF, 32'hFFFF_FFFF,
                                           15'h7FFF));
        requests_to_send.push_back(add_req(16'h8000, 16'h7FFF, 16'h0001, 32'h0000_0000,
                                           15'h0000));
        requests_to_send.push_back(add_req(16'h1234, 16'hFA99, 16'h0300, $urandom, 15'h0001));
        requests_to_send.push_back(blank_req(OP_DRAW));
        // Longest time step at the reset rate: kills the short lives, spares the longest.
        requests_to_send.push_back(tick_req(16'hFFFF));
        requests_to_send.push_back(blank_req(OP_DRAW));
        settle();

        // Largest decay and time step wipe the pool.
        write_reg(CFG_DECAY, 16'hFFFF);
        @(posedge i_clk);
        requests_to_send.push_back(tick_req(16'hFFFF));
        requests_to_send.push_back(blank_req(OP_DRAW));
        settle();

        // No decay: fill slots 2 to 7, leaving the search pointer at 7.
        write_reg(CFG_DECAY, 16'h0000);
        @(posedge i_clk);
        repeat (6) requests_to_send.push_back(add_req(16'($urandom), 16'($urandom),
                                                      16'($urandom_range(1, 65535)),
                                                      $urandom, 15'($urandom)));
        settle();

        // Shrink the span below the pointer: the search restarts at slot 0, which is dead.
        write_reg(CFG_SLOTS, 16'd4);
        @(posedge i_clk);
        requests_to_send.push_back(add_req(16'($urandom), 16'($urandom), 16'h0040, $urandom,
                                           15'($urandom)));
        settle();

        // Empty span: add lands on slot 0, draw finds nothing, tick does nothing.
        write_reg(CFG_SLOTS, 16'd0);
        @(posedge i_clk);
        requests_to_send.push_back(add_req(16'($urandom), 16'($urandom), 16'h0080, $urandom,
                                           15'($urandom)));
        requests_to_send.push_back(blank_req(OP_DRAW));
        requests_to_send.push_back(tick_req(16'hFFFF));
        settle();

        // Span above the pool size counts as the whole pool.
        write_reg(CFG_SLOTS, 16'd127);
        @(posedge i_clk);
        requests_to_send.push_back(blank_req(OP_DRAW));
        settle();

        // Random phases, each with its own idling pattern and register setting.
        run_phase(0, 0, 16'd26, 16'd64, 28, 1'b0);
        run_phase(67, 0, 16'hFFFF, 16'd8, 28, 1'b0);
        run_phase(0, 67, 16'd0, 16'd1, 28, 1'b0);
        run_phase(8, 8, 16'($urandom), 16'($urandom_range(1, 64)), 28, 1'b0);
        // Upper data bits set: the span register keeps only its low seven bits (64).
        run_phase(0, 0, 16'd26, 16'hFFC0, 28, 1'b1);

        if (faults == 0) begin
            $display("PASS particle_pool_allocator");
        end else begin
            $display("FAIL particle_pool_allocator");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/ppa_pkg.sv
sv/ppa_ifs.sv
sv/ppa_ram.sv
sv/ppa_front.sv
sv/ppa_queue.sv
sv/ppa_back.sv
sv/particle_pool_allocator.sv
verif/testbench.sv
